/* src/dhcp_option_field_extractor_top_defines.svh */
// Assertion macros for the DHCP option field extractor RTL.
`ifndef DHCP_OPTION_FIELD_EXTRACTOR_TOP_DEFINES_SVH
`define DHCP_OPTION_FIELD_EXTRACTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DOFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DOFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dofe_pkg.sv */
// Package of option codes, parse phase codes and the result type.
`timescale 1ns / 1ps
package dofe_pkg;

    localparam logic [7:0] OPT_PAD    = 8'd0;
    localparam logic [7:0] OPT_MASK   = 8'd1;
    localparam logic [7:0] OPT_ROUTER = 8'd3;
    localparam logic [7:0] OPT_DNS    = 8'd6;
    localparam logic [7:0] OPT_LEASE  = 8'd51;
    localparam logic [7:0] OPT_TYPE   = 8'd53;
    localparam logic [7:0] OPT_SERVER = 8'd54;
    localparam logic [7:0] OPT_END    = 8'd255;

    localparam logic [1:0] PH_CODE  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [2:0]  VALUE_BYTES = 3'd4;
    localparam logic [31:0] LEASE_INIT  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]  message_type;
        logic [31:0] subnet_mask;
        logic [31:0] router_addr;
        logic [31:0] dns_addr;
        logic [31:0] server_ident;
        logic [31:0] lease_min;
    } result_t;

endpackage

/* src/dofe_parse.sv */
// Option record walker: parse state, held option values and the next result.
`timescale 1ns / 1ps
`include "dhcp_option_field_extractor_top_defines.svh"
module dofe_parse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       option_byte,
    input  logic             last_byte,
    output dofe_pkg::result_t res_next
);
    import dofe_pkg::*;

    logic [1:0]  phase_reg, phase_next, phase_proc;
    logic [7:0]  code_reg, code_next, code_proc;
    logic [7:0]  left_reg, left_next, left_proc;
    logic [2:0]  count_reg, count_next, count_proc;
    logic [31:0] shift_reg, shift_next, shift_proc;
    logic [7:0]  type_reg, type_next, type_proc;
    logic [31:0] mask_reg, mask_next;
    logic [31:0] router_reg, router_next;
    logic [31:0] dns_reg, dns_next;
    logic [31:0] server_reg, server_next;
    logic [31:0] lease_reg, lease_next;

    always_comb
    begin
        phase_proc  = phase_reg;
        code_proc   = code_reg;
        left_proc   = left_reg;
        count_proc  = count_reg;
        shift_proc  = shift_reg;
        type_proc   = type_reg;
        mask_next   = mask_reg;
        router_next = router_reg;
        dns_next    = dns_reg;
        server_next = server_reg;
        lease_next  = lease_reg;

        unique case (phase_reg)
            PH_CODE:
            begin
                if (option_byte == OPT_END)
                begin
                    phase_proc = PH_DONE;
                end
                else if (option_byte != OPT_PAD)
                begin
                    code_proc  = option_byte;
                    phase_proc = PH_LEN;
                end
            end
            PH_LEN:
            begin
                left_proc  = option_byte;
                count_proc = 3'd0;
                shift_proc = 32'd0;
                phase_proc = (option_byte == 8'd0) ? PH_CODE : PH_VALUE;
            end
            PH_VALUE:
            begin
                // Only the first four value bytes are gathered; the rest are skipped.
                if (count_reg < VALUE_BYTES)
                begin
                    shift_proc = {shift_reg[23:0], option_byte};
                    count_proc = count_reg + 3'd1;
                    if (code_reg == OPT_TYPE && count_proc == 3'd1)
                    begin
                        type_proc = option_byte;
                    end
                    else if (count_proc == VALUE_BYTES)
                    begin
                        unique case (code_reg)
                            OPT_MASK:   mask_next   = shift_proc;
                            OPT_ROUTER: router_next = shift_proc;
                            OPT_DNS:    dns_next    = shift_proc;
                            OPT_SERVER: server_next = shift_proc;
                            OPT_LEASE:
                            begin
                                if (shift_proc < lease_reg)
                                begin
                                    lease_next = shift_proc;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                left_proc = left_reg - 8'd1;
                if (left_reg == 8'd1)
                begin
                    phase_proc = PH_CODE;
                end
            end
            PH_DONE:
            begin
            end
        endcase

        res_next.message_type = type_proc;
        res_next.subnet_mask  = mask_next;
        res_next.router_addr  = router_next;
        res_next.dns_addr     = dns_next;
        res_next.server_ident = server_next;
        res_next.lease_min    = lease_next;

        // The final byte of a message restarts the per-message parse state.
        if (last_byte)
        begin
            phase_next = PH_CODE;
            code_next  = 8'd0;
            left_next  = 8'd0;
            count_next = 3'd0;
            shift_next = 32'd0;
            type_next  = 8'd0;
        end
        else
        begin
            phase_next = phase_proc;
            code_next  = code_proc;
            left_next  = left_proc;
            count_next = count_proc;
            shift_next = shift_proc;
            type_next  = type_proc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CODE;
            code_reg   <= 8'd0;
            left_reg   <= 8'd0;
            count_reg  <= 3'd0;
            shift_reg  <= 32'd0;
            type_reg   <= 8'd0;
            mask_reg   <= 32'd0;
            router_reg <= 32'd0;
            dns_reg    <= 32'd0;
            server_reg <= 32'd0;
            lease_reg  <= LEASE_INIT;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            code_reg   <= code_next;
            left_reg   <= left_next;
            count_reg  <= count_next;
            shift_reg  <= shift_next;
            type_reg   <= type_next;
            mask_reg   <= mask_next;
            router_reg <= router_next;
            dns_reg    <= dns_next;
            server_reg <= server_next;
            lease_reg  <= lease_next;
        end
    end

    `DOFE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= VALUE_BYTES,
        "value byte count went past four")
    `DOFE_ASSERT_NOW(a_value_left, phase_reg == PH_VALUE, left_reg != 8'd0,
        "inside a value with no bytes left")
    `DOFE_ASSERT_NEXT(a_restart, step && last_byte,
        phase_reg == PH_CODE && type_reg == 8'd0 && count_reg == 3'd0,
        "parse state not restarted after the final byte")
    `DOFE_ASSERT_NEXT(a_lease_min, step, lease_reg <= $past(lease_reg),
        "lease minimum increased")

endmodule

/* src/dofe_out_stage.sv */
// Result register holding one finished item until the consumer takes it.
`timescale 1ns / 1ps
module dofe_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  dofe_pkg::result_t res,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        message_type,
    output logic [31:0]       subnet_mask,
    output logic [31:0]       router_addr,
    output logic [31:0]       dns_addr,
    output logic [31:0]       server_ident,
    output logic [31:0]       lease_min
);
    import dofe_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = valid_reg;
    assign message_type = res_reg.message_type;
    assign subnet_mask  = res_reg.subnet_mask;
    assign router_addr  = res_reg.router_addr;
    assign dns_addr     = res_reg.dns_addr;
    assign server_ident = res_reg.server_ident;
    assign lease_min    = res_reg.lease_min;

endmodule

/* src/dhcp_option_field_extractor_top.sv */
// Top level of the DHCP option field extractor: input register, parser and result register.
`timescale 1ns / 1ps
// Takes the DHCP options area (the bytes after the magic cookie) one byte per item and
// gives one result item on the byte marked last_byte: message type, subnet mask, router,
// DNS server, server identifier and the smallest lease time seen. A new byte is accepted
// in every cycle while the input does not stall; the sustained rate is then one item per
// clock, set by the parse step whose state feeds back to the next byte. A last byte waits in
// the input register until the result register has room, and the result register loads as
// that byte leaves the input register. Held addresses and the lease minimum persist across
// messages until reset; the parse position and the message type restart after every last
// byte. The input stalls only while a finished result is still waiting and the next last
// byte is ready to be processed.
module dhcp_option_field_extractor_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  option_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  message_type,
    output logic [31:0] subnet_mask,
    output logic [31:0] router_addr,
    output logic [31:0] dns_addr,
    output logic [31:0] server_ident,
    output logic [31:0] lease_min
);
    import dofe_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_free;
    logic       advance;
    logic       accept;
    result_t    res_next;

    // An ordinary byte always moves on; a last byte needs room in the result register.
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign in_ready = !in_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= option_byte;
            in_last_reg <= last_byte;
        end
    end

    dofe_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .option_byte (in_byte_reg),
        .last_byte   (in_last_reg),
        .res_next    (res_next)
    );

    dofe_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && in_last_reg),
        .res          (res_next),
        .free         (out_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .message_type (message_type),
        .subnet_mask  (subnet_mask),
        .router_addr  (router_addr),
        .dns_addr     (dns_addr),
        .server_ident (server_ident),
        .lease_min    (lease_min)
    );

endmodule
